### design/yincmd_pkg.sv
`timescale 1ns / 1ps
package yincmd_pkg;

  localparam int MAX_WINDOW  = 512;
  localparam int MAX_LAGS    = 64;
  localparam int STORE_DEPTH = MAX_WINDOW + MAX_LAGS;

  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int WLEN_W   = 10;
  localparam int NLAG_W   = 7;
  localparam int LAG_W    = 6;
  localparam int ND_W     = 23;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 32;
  localparam int NUM_W    = SUM_W + LAG_W;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT     = 1'd1;

  localparam logic [WLEN_W-1:0] WINDOW_RESET = 10'd256;
  localparam logic [NLAG_W-1:0] LAGS_RESET   = 7'd64;
  localparam logic [ND_W-1:0]   ONE_Q16      = 23'd65536;

  typedef struct packed {
    logic                       clear;
    logic                       feed;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] x;
    logic [ADDR_W-1:0]          n;
    logic [WLEN_W-1:0]          w;
  } cell_ctrl_t;

endpackage

### design/yincmd_ifs.sv
`timescale 1ns / 1ps
interface yincmd_sample_if;
  import yincmd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface yincmd_result_if;
  import yincmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [LAG_W-1:0] lag_index;
  logic [ND_W-1:0]  norm_diff;
  logic             last_lag;
  modport source (output valid, output lag_index, output norm_diff, output last_lag,
                  input ready);
  modport sink (input valid, input lag_index, input norm_diff, input last_lag,
                output ready);
endinterface

### design/yincmd_cell.sv
`timescale 1ns / 1ps
module yincmd_cell (
  input  logic                                  clk,
  input  yincmd_pkg::cell_ctrl_t                ctrl,
  input  logic [yincmd_pkg::LAG_W-1:0]          lag,
  input  logic signed [yincmd_pkg::SAMPLE_W-1:0] tap_in,
  output logic signed [yincmd_pkg::SAMPLE_W-1:0] tap_out,
  input  logic [yincmd_pkg::SUM_W-1:0]          acc_in,
  output logic [yincmd_pkg::SUM_W-1:0]          acc_out
);
  import yincmd_pkg::*;

  logic signed [SAMPLE_W-1:0] tap;
  logic signed [SAMPLE_W:0]   diff;
  logic [SQ_W-1:0]            sq;
  logic                       sq_en;
  logic [SUM_W-1:0]           acc;
  logic [SUM_W:0]             acc_sum;
  logic                       in_window;
  logic [ADDR_W-1:0]          k;

  assign diff      = {ctrl.x[SAMPLE_W-1], ctrl.x} - {tap[SAMPLE_W-1], tap};
  assign k         = ctrl.n - ADDR_W'(lag);
  assign in_window = (ctrl.n >= ADDR_W'(lag)) && (k < ADDR_W'(ctrl.w));
  assign acc_sum   = {1'b0, acc} + (SUM_W+1)'(sq);
  assign tap_out   = tap;
  assign acc_out   = acc;

  always_ff @(posedge clk) begin
    if (ctrl.feed) begin
      tap <= tap_in;
      sq  <= SQ_W'(diff * diff);
    end
    if (ctrl.clear) begin
      sq_en <= 1'b0;
      acc   <= '0;
    end else begin
      sq_en <= ctrl.feed && in_window;
      if (ctrl.shift) begin
        acc <= acc_in;
      end else if (sq_en) begin
        acc <= acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
      end
    end
  end
endmodule

### design/yin_cumulative_mean_difference.sv
`timescale 1ns / 1ps
// yin cumulative mean normalized difference over one audio frame
// samples: one signed 16-bit sample per transfer; a frame is window_length
//   plus lag_count samples, written into a 576-entry sample memory
// results: lag_count transfers per frame, lag 0 first (65536), then lags
//   1..lag_count-1 in unsigned q7.16, last_lag set on the final one
// cfg: write enable, index (0 window_length, 1 lag_count) and data; values
//   are clamped to 1..512 and 2..64 at the end of a frame
// after the last sample the memory is swept once, one sample a cycle
//   through a row of 63 lag cells, each squaring and accumulating its own
//   lag; S_DRAIN then lets the cells finish their last accumulations
// each lag then goes through accumulator shift out, running sum,
//   multiply by the lag and a 23-step restoring divider
// samples are not taken while a frame is processed
// a stalled receiver holds the result register and the lag sequence waits
// reset clears the control state and restores the reset configuration
module yin_cumulative_mean_difference (
  input  logic                               clk,
  input  logic                               rst,
  yincmd_sample_if.sink                      samples,
  yincmd_result_if.source                    results,
  input  logic                               cfg_we,
  input  logic [yincmd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [yincmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yincmd_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_SWEEP, S_DRAIN, S_EMIT0, S_PICK, S_MUL, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;

  logic [WLEN_W-1:0] window_length;
  logic [NLAG_W-1:0] lag_count;
  logic [WLEN_W-1:0] w_eff;
  logic [NLAG_W-1:0] nl_eff;
  logic [WLEN_W-1:0] frame_w;
  logic [NLAG_W-1:0] frame_nl;
  logic [ADDR_W-1:0] frame_len;
  logic [ADDR_W:0]   cur_len;
  logic [ADDR_W-1:0] loaded;
  logic [ADDR_W:0]   loaded_next;
  logic [ADDR_W-1:0] rd_addr;
  logic              feed_v;
  logic [ADDR_W-1:0] feed_n;
  logic [1:0]        drain_cnt;
  logic [LAG_W-1:0]  lag;
  logic [SUM_W-1:0]  d;
  logic [SUM_W-1:0]  running;
  logic [SUM_W:0]    run_sum;
  logic [SUM_W-1:0]  den;
  logic [NUM_W-1:0]  num;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    trial;
  logic [ND_W-1:0]   quo;
  logic [ND_W-1:0]   feed_bits;
  logic [4:0]        step;
  logic [ND_W-1:0]   cap;
  logic              in_xfer;
  logic              out_xfer;

  cell_ctrl_t ctrl;
  logic signed [SAMPLE_W-1:0] tap_link [MAX_LAGS];
  logic [SUM_W-1:0]           acc_link [1:MAX_LAGS];

  assign w_eff   = (window_length == '0) ? WLEN_W'(1)
                 : (window_length > WLEN_W'(MAX_WINDOW)) ? WLEN_W'(MAX_WINDOW)
                 : window_length;
  assign nl_eff  = (lag_count < NLAG_W'(2)) ? NLAG_W'(2)
                 : (lag_count > NLAG_W'(MAX_LAGS)) ? NLAG_W'(MAX_LAGS)
                 : lag_count;
  assign cur_len     = (ADDR_W+1)'(w_eff) + (ADDR_W+1)'(nl_eff);
  assign loaded_next = {1'b0, loaded} + 1'b1;
  assign in_xfer     = samples.valid && samples.ready;
  assign out_xfer    = results.valid && results.ready;
  assign samples.ready = (state == S_LOAD);

  assign run_sum = {1'b0, running} + {1'b0, acc_link[1]};
  assign den     = (running == '0) ? SUM_W'(1) : running;
  assign trial   = {rem, feed_bits[ND_W-1]};
  assign cap     = {1'b0, lag, {FRAC_W{1'b0}}};

  assign ctrl.clear = (state == S_LOAD);
  assign ctrl.feed  = feed_v;
  assign ctrl.shift = (state == S_PICK);
  assign ctrl.x     = rdata;
  assign ctrl.n     = feed_n;
  assign ctrl.w     = frame_w;

  assign tap_link[0]        = rdata;
  assign acc_link[MAX_LAGS] = '0;

  for (genvar g = 1; g < MAX_LAGS; g++) begin : g_cell
    yincmd_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .lag     (LAG_W'(g)),
      .tap_in  (tap_link[g-1]),
      .tap_out (tap_link[g]),
      .acc_in  (acc_link[g+1]),
      .acc_out (acc_link[g])
    );
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[loaded] <= samples.sample;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      window_length <= WINDOW_RESET;
      lag_count     <= LAGS_RESET;
      loaded        <= '0;
      rd_addr       <= '0;
      feed_v        <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
          REG_LAG_COUNT:     lag_count     <= cfg_data[NLAG_W-1:0];
          default: ;
        endcase
      end
      if (out_xfer) begin
        results.valid <= 1'b0;
      end
      feed_v <= (state == S_SWEEP);
      feed_n <= rd_addr;
      case (state)
        S_LOAD: begin
          rd_addr <= '0;
          if (in_xfer) begin
            if (loaded_next >= cur_len) begin
              loaded    <= '0;
              frame_w   <= w_eff;
              frame_nl  <= nl_eff;
              frame_len <= ADDR_W'(cur_len);
              state     <= S_SWEEP;
            end else begin
              loaded <= ADDR_W'(loaded_next);
            end
          end
        end
        S_SWEEP: begin
          rd_addr <= rd_addr + 1'b1;
          if (rd_addr == frame_len - 1'b1) begin
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == 2'd3) begin
            state <= S_EMIT0;
          end
        end
        S_EMIT0: begin
          running <= '0;
          lag     <= LAG_W'(1);
          if (!results.valid) begin
            results.valid     <= 1'b1;
            results.lag_index <= '0;
            results.norm_diff <= ONE_Q16;
            results.last_lag  <= 1'b0;
            state             <= S_PICK;
          end
        end
        S_PICK: begin
          d       <= acc_link[1];
          running <= run_sum[SUM_W] ? {SUM_W{1'b1}} : run_sum[SUM_W-1:0];
          state   <= S_MUL;
        end
        S_MUL: begin
          num   <= d * lag;
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == '0) begin
            rem       <= SUM_W'(num[NUM_W-1:7]);
            feed_bits <= {num[6:0], {FRAC_W{1'b0}}};
            quo       <= '0;
            step      <= step + 1'b1;
          end else begin
            feed_bits <= feed_bits << 1;
            if (trial >= {1'b0, den}) begin
              rem <= SUM_W'(trial - {1'b0, den});
              quo <= {quo[ND_W-2:0], 1'b1};
            end else begin
              rem <= trial[SUM_W-1:0];
              quo <= {quo[ND_W-2:0], 1'b0};
            end
            if (step == 5'(ND_W)) begin
              state <= S_OUT;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!results.valid) begin
            results.valid     <= 1'b1;
            results.lag_index <= lag;
            results.norm_diff <= (quo > cap) ? cap : quo;
            results.last_lag  <= (NLAG_W'(lag) == frame_nl - 1'b1);
            if (NLAG_W'(lag) == frame_nl - 1'b1) begin
              state <= S_LOAD;
            end else begin
              lag   <= lag + 1'b1;
              state <= S_PICK;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

### design/yincmd_checker.sv
`timescale 1ns / 1ps
module yincmd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [yincmd_pkg::LAG_W-1:0]   lag_index,
  input logic [yincmd_pkg::ND_W-1:0]    norm_diff,
  input logic                           last_lag
);
  import yincmd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_lag0: assert property (@(posedge clk) disable iff (rst)
    out_valid && lag_index == '0 |-> norm_diff == ONE_Q16 && !last_lag)
    else $error("lag 0 result wrong");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && lag_index != '0 |->
      (norm_diff[ND_W-1:FRAC_W] < {1'b0, lag_index}) ||
      (norm_diff[ND_W-1:FRAC_W] == {1'b0, lag_index} && norm_diff[FRAC_W-1:0] == '0))
    else $error("normalized difference above lag");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_lag |=> !out_valid || lag_index != '0)
    else $error("frame restarted before last lag");

endmodule

bind yin_cumulative_mean_difference yincmd_checker u_yincmd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .lag_index (results.lag_index),
  .norm_diff (results.norm_diff),
  .last_lag  (results.last_lag)
);
